// ===== rtl/pscu_pkg.sv =====
`timescale 1ns / 1ps

package pscu_pkg;

  // Field widths of the channel words
  localparam int FIELD_W = 11;
  localparam int KIND_W  = 2;

  // Defaults
  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int USED_RESET      = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SWAP  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_RDPA,
    ST_SW_RDPB,
    ST_SW_WRA,
    ST_SW_WRB,
    ST_LEAF_A,
    ST_LEAF_B,
    ST_UP_RD,
    ST_UP_WR,
    ST_Q_L,
    ST_Q_R,
    ST_Q_SH,
    ST_Q_OUT,
    ST_Q_BAD
  } state_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    DP_CAPTURE,
    DP_DECODE,
    DP_LOAD,
    DP_SW_RDA,
    DP_SW_RDB,
    DP_SW_RDPA,
    DP_SW_RDPB,
    DP_SW_WRA,
    DP_SW_WRB,
    DP_LEAF_A,
    DP_LEAF_B,
    DP_UP_RD,
    DP_UP_WR,
    DP_Q_L,
    DP_Q_R,
    DP_Q_SH,
    DP_Q_OUT,
    DP_Q_BAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  load_ok;
    logic  swap_ok;
    logic  query_ok;
    logic  top;
    logic  q_done;
    logic  out_free;
  } dp_sts_t;

endpackage

// ===== rtl/pscu_if.sv =====
`timescale 1ns / 1ps

// Input word channel
interface pscu_in_if;
  logic                        valid;
  logic                        ready;
  logic [pscu_pkg::KIND_W-1:0] kind;
  logic [pscu_pkg::FIELD_W-1:0] first;
  logic [pscu_pkg::FIELD_W-1:0] second;
  modport source (output valid, kind, first, second, input ready);
  modport sink (input valid, kind, first, second, output ready);
endinterface

// Result word channel
interface pscu_out_if;
  logic                         valid;
  logic                         ready;
  logic                         contiguous;
  logic [pscu_pkg::FIELD_W-1:0] min_position;
  logic [pscu_pkg::FIELD_W-1:0] max_position;
  modport source (output valid, contiguous, min_position, max_position, input ready);
  modport sink (input valid, contiguous, min_position, max_position, output ready);
endinterface

// Configuration write channel
interface pscu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pscu_pkg::FIELD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/pscu_ctrl.sv =====
`timescale 1ns / 1ps

module pscu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output pscu_pkg::dp_cmd_t cmd,
  input  pscu_pkg::dp_sts_t sts
);

  pscu_pkg::state_t state_r, state_nxt;
  logic             pend_b_r, pend_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pscu_pkg::ST_IDLE;
      pend_b_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_b_r <= pend_b_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    pend_b_nxt = pend_b_r;
    case (state_r)
      pscu_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pscu_pkg::ST_DECODE;
      end
      pscu_pkg::ST_DECODE: begin
        case (sts.kind)
          pscu_pkg::KIND_LOAD:
            state_nxt = sts.load_ok ? pscu_pkg::ST_LOAD : pscu_pkg::ST_IDLE;
          pscu_pkg::KIND_SWAP:
            state_nxt = sts.swap_ok ? pscu_pkg::ST_SW_RDA : pscu_pkg::ST_IDLE;
          pscu_pkg::KIND_QUERY:
            state_nxt = sts.query_ok ? pscu_pkg::ST_Q_L : pscu_pkg::ST_Q_BAD;
          default: state_nxt = pscu_pkg::ST_IDLE;
        endcase
      end
      pscu_pkg::ST_LOAD:    state_nxt = pscu_pkg::ST_UP_RD;
      pscu_pkg::ST_SW_RDA:  state_nxt = pscu_pkg::ST_SW_RDB;
      pscu_pkg::ST_SW_RDB:  state_nxt = pscu_pkg::ST_SW_RDPA;
      pscu_pkg::ST_SW_RDPA: state_nxt = pscu_pkg::ST_SW_RDPB;
      pscu_pkg::ST_SW_RDPB: state_nxt = pscu_pkg::ST_SW_WRA;
      pscu_pkg::ST_SW_WRA:  state_nxt = pscu_pkg::ST_SW_WRB;
      pscu_pkg::ST_SW_WRB:  state_nxt = pscu_pkg::ST_LEAF_A;
      pscu_pkg::ST_LEAF_A: begin
        state_nxt  = pscu_pkg::ST_UP_RD;
        pend_b_nxt = 1'b1;
      end
      pscu_pkg::ST_LEAF_B: begin
        state_nxt  = pscu_pkg::ST_UP_RD;
        pend_b_nxt = 1'b0;
      end
      pscu_pkg::ST_UP_RD: state_nxt = pscu_pkg::ST_UP_WR;
      pscu_pkg::ST_UP_WR: begin
        if (!sts.top)     state_nxt = pscu_pkg::ST_UP_RD;
        else if (pend_b_r) state_nxt = pscu_pkg::ST_LEAF_B;
        else              state_nxt = pscu_pkg::ST_IDLE;
      end
      pscu_pkg::ST_Q_L: state_nxt = sts.q_done ? pscu_pkg::ST_Q_OUT : pscu_pkg::ST_Q_R;
      pscu_pkg::ST_Q_R:  state_nxt = pscu_pkg::ST_Q_SH;
      pscu_pkg::ST_Q_SH: state_nxt = pscu_pkg::ST_Q_L;
      pscu_pkg::ST_Q_OUT, pscu_pkg::ST_Q_BAD: begin
        if (sts.out_free) state_nxt = pscu_pkg::ST_IDLE;
      end
      default: state_nxt = pscu_pkg::ST_IDLE;
    endcase
  end

  // Outputs: one datapath op per state
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = pscu_pkg::DP_CAPTURE;
    case (state_r)
      pscu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = pscu_pkg::DP_CAPTURE;
      end
      pscu_pkg::ST_DECODE:  cmd.op = pscu_pkg::DP_DECODE;
      pscu_pkg::ST_LOAD:    cmd.op = pscu_pkg::DP_LOAD;
      pscu_pkg::ST_SW_RDA:  cmd.op = pscu_pkg::DP_SW_RDA;
      pscu_pkg::ST_SW_RDB:  cmd.op = pscu_pkg::DP_SW_RDB;
      pscu_pkg::ST_SW_RDPA: cmd.op = pscu_pkg::DP_SW_RDPA;
      pscu_pkg::ST_SW_RDPB: cmd.op = pscu_pkg::DP_SW_RDPB;
      pscu_pkg::ST_SW_WRA:  cmd.op = pscu_pkg::DP_SW_WRA;
      pscu_pkg::ST_SW_WRB:  cmd.op = pscu_pkg::DP_SW_WRB;
      pscu_pkg::ST_LEAF_A:  cmd.op = pscu_pkg::DP_LEAF_A;
      pscu_pkg::ST_LEAF_B:  cmd.op = pscu_pkg::DP_LEAF_B;
      pscu_pkg::ST_UP_RD:   cmd.op = pscu_pkg::DP_UP_RD;
      pscu_pkg::ST_UP_WR:   cmd.op = pscu_pkg::DP_UP_WR;
      pscu_pkg::ST_Q_L:     cmd.op = pscu_pkg::DP_Q_L;
      pscu_pkg::ST_Q_R:     cmd.op = pscu_pkg::DP_Q_R;
      pscu_pkg::ST_Q_SH:    cmd.op = pscu_pkg::DP_Q_SH;
      pscu_pkg::ST_Q_OUT:   cmd.op = pscu_pkg::DP_Q_OUT;
      pscu_pkg::ST_Q_BAD:   cmd.op = pscu_pkg::DP_Q_BAD;
      default:              cmd.op = pscu_pkg::DP_CAPTURE;
    endcase
  end

endmodule

// ===== rtl/pscu_dp.sv =====
`timescale 1ns / 1ps

module pscu_dp #(
  parameter int MAX_ENTRIES = pscu_pkg::DEF_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pscu_pkg::dp_cmd_t            cmd,
  output pscu_pkg::dp_sts_t            sts,
  input  logic                         in_valid,
  input  logic [pscu_pkg::KIND_W-1:0]  in_kind,
  input  logic [pscu_pkg::FIELD_W-1:0] in_first,
  input  logic [pscu_pkg::FIELD_W-1:0] in_second,
  input  logic                         cfg_valid,
  input  logic [pscu_pkg::FIELD_W-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_contiguous,
  output logic [pscu_pkg::FIELD_W-1:0] out_min_position,
  output logic [pscu_pkg::FIELD_W-1:0] out_max_position
);

  localparam int FW = pscu_pkg::FIELD_W;
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int TW = $clog2(2 * MAX_ENTRIES);
  localparam int QW = $clog2(2 * MAX_ENTRIES + 1);

  // Stores: value at position, position of value, min/max position tree
  logic [FW-1:0] val_mem  [MAX_ENTRIES];
  logic [FW-1:0] pos_mem  [MAX_ENTRIES];
  logic [FW-1:0] tmin_mem [2*MAX_ENTRIES];
  logic [FW-1:0] tmax_mem [2*MAX_ENTRIES];

  logic [FW-1:0] val_q, pos_q, tmin_q, tmax_q;

  logic [FW-1:0] used_r;
  pscu_pkg::kind_t kind_r;
  logic [FW-1:0] a_r, b_r;
  logic [FW-1:0] va_r, vb_r, pa_r, pb_r;
  logic [TW-1:0] idx_r;
  logic [FW-1:0] cmin_r, cmax_r;
  logic [QW-1:0] l_r, r_r;
  logic [FW-1:0] mn_r, mx_r;
  logic          pend_r;
  logic          out_valid_r;
  logic          cont_r;
  logic [FW-1:0] omin_r, omax_r;

  logic [FW-1:0] n;
  logic          a_in, b_in, out_free;
  logic [FW-1:0] nmin, nmax, amin, amax;

  logic          val_we, pos_we, tree_we;
  logic [IW-1:0] val_ra, val_wa, pos_ra, pos_wa;
  logic [FW-1:0] val_wd, pos_wd, tree_wmin, tree_wmax;
  logic [TW-1:0] tree_ra, tree_wa;

  function automatic logic [IW-1:0] slot(input logic [FW-1:0] v);
    logic [FW-1:0] d;
    d = v - FW'(1);
    return IW'(d);
  endfunction

  function automatic logic [TW-1:0] leaf(input logic [FW-1:0] v);
    return TW'(MAX_ENTRIES) + TW'(v) - TW'(1);
  endfunction

  // Active entry count, saturated to the store depth
  assign n = (32'(used_r) > 32'(MAX_ENTRIES)) ? FW'(MAX_ENTRIES) : used_r;
  assign a_in = (a_r != '0) && (a_r <= n);
  assign b_in = (b_r != '0) && (b_r <= n);
  assign out_free = !out_valid_r || out_ready;

  assign sts.kind     = kind_r;
  assign sts.load_ok  = a_in && b_in;
  assign sts.swap_ok  = a_in && b_in;
  assign sts.query_ok = (a_r != '0) && (b_r <= n) && (a_r <= b_r);
  assign sts.top      = (idx_r >> 1) == TW'(1);
  assign sts.q_done   = l_r >= r_r;
  assign sts.out_free = out_free;

  // Combine for a tree level and for query accumulation
  assign nmin = (tmin_q < cmin_r) ? tmin_q : cmin_r;
  assign nmax = (tmax_q > cmax_r) ? tmax_q : cmax_r;
  assign amin = (pend_r && tmin_q < mn_r) ? tmin_q : mn_r;
  assign amax = (pend_r && tmax_q > mx_r) ? tmax_q : mx_r;

  // Memory port control
  always_comb begin
    val_we    = 1'b0;
    val_wa    = slot(a_r);
    val_wd    = b_r;
    val_ra    = slot(a_r);
    pos_we    = 1'b0;
    pos_wa    = slot(b_r);
    pos_wd    = a_r;
    pos_ra    = slot(va_r);
    tree_we   = 1'b0;
    tree_wa   = leaf(b_r);
    tree_wmin = a_r;
    tree_wmax = a_r;
    tree_ra   = idx_r ^ TW'(1);
    case (cmd.op)
      pscu_pkg::DP_LOAD: begin
        val_we  = 1'b1;
        pos_we  = 1'b1;
        tree_we = 1'b1;
      end
      pscu_pkg::DP_SW_RDB:  val_ra = slot(b_r);
      pscu_pkg::DP_SW_RDPB: pos_ra = slot(vb_r);
      pscu_pkg::DP_SW_WRA: begin
        val_we = 1'b1;
        val_wa = slot(a_r);
        val_wd = vb_r;
        pos_we = 1'b1;
        pos_wa = slot(va_r);
        pos_wd = pos_q;
      end
      pscu_pkg::DP_SW_WRB: begin
        val_we = 1'b1;
        val_wa = slot(b_r);
        val_wd = va_r;
        pos_we = 1'b1;
        pos_wa = slot(vb_r);
        pos_wd = pa_r;
      end
      pscu_pkg::DP_LEAF_A: begin
        tree_we   = 1'b1;
        tree_wa   = leaf(va_r);
        tree_wmin = pb_r;
        tree_wmax = pb_r;
      end
      pscu_pkg::DP_LEAF_B: begin
        tree_we   = 1'b1;
        tree_wa   = leaf(vb_r);
        tree_wmin = pa_r;
        tree_wmax = pa_r;
      end
      pscu_pkg::DP_UP_WR: begin
        tree_we   = 1'b1;
        tree_wa   = idx_r >> 1;
        tree_wmin = nmin;
        tree_wmax = nmax;
      end
      pscu_pkg::DP_Q_L: tree_ra = TW'(l_r);
      pscu_pkg::DP_Q_R: tree_ra = TW'(r_r - QW'(1));
      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_q <= val_mem[val_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tmin_mem[tree_wa] <= tree_wmin;
      tmax_mem[tree_wa] <= tree_wmax;
    end
    tmin_q <= tmin_mem[tree_ra];
    tmax_q <= tmax_mem[tree_ra];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= FW'(pscu_pkg::USED_RESET);
    else if (cfg_valid) used_r <= cfg_data;
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pscu_pkg::DP_CAPTURE: begin
        if (in_valid) begin
          kind_r <= pscu_pkg::kind_t'(in_kind);
          a_r    <= in_first;
          b_r    <= in_second;
        end
      end
      pscu_pkg::DP_DECODE: begin
        l_r    <= QW'(MAX_ENTRIES) + QW'(a_r) - QW'(1);
        r_r    <= QW'(MAX_ENTRIES) + QW'(b_r);
        mn_r   <= '1;
        mx_r   <= '0;
        pend_r <= 1'b0;
      end
      pscu_pkg::DP_LOAD: begin
        idx_r  <= leaf(b_r);
        cmin_r <= a_r;
        cmax_r <= a_r;
      end
      pscu_pkg::DP_SW_RDB:  va_r <= val_q;
      pscu_pkg::DP_SW_RDPA: vb_r <= val_q;
      pscu_pkg::DP_SW_RDPB: pa_r <= pos_q;
      pscu_pkg::DP_SW_WRA:  pb_r <= pos_q;
      pscu_pkg::DP_LEAF_A: begin
        idx_r  <= leaf(va_r);
        cmin_r <= pb_r;
        cmax_r <= pb_r;
      end
      pscu_pkg::DP_LEAF_B: begin
        idx_r  <= leaf(vb_r);
        cmin_r <= pa_r;
        cmax_r <= pa_r;
      end
      pscu_pkg::DP_UP_WR: begin
        idx_r  <= idx_r >> 1;
        cmin_r <= nmin;
        cmax_r <= nmax;
      end
      pscu_pkg::DP_Q_L: begin
        pend_r <= l_r[0];
        if (l_r[0]) l_r <= l_r + QW'(1);
      end
      pscu_pkg::DP_Q_R: begin
        mn_r   <= amin;
        mx_r   <= amax;
        pend_r <= r_r[0];
        if (r_r[0]) r_r <= r_r - QW'(1);
      end
      pscu_pkg::DP_Q_SH: begin
        mn_r   <= amin;
        mx_r   <= amax;
        pend_r <= 1'b0;
        l_r    <= l_r >> 1;
        r_r    <= r_r >> 1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free && (cmd.op inside {pscu_pkg::DP_Q_OUT, pscu_pkg::DP_Q_BAD})) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && cmd.op == pscu_pkg::DP_Q_OUT) begin
      cont_r <= (mx_r >= mn_r) && ((mx_r - mn_r) == (b_r - a_r));
      omin_r <= mn_r;
      omax_r <= mx_r;
    end else if (out_free && cmd.op == pscu_pkg::DP_Q_BAD) begin
      cont_r <= 1'b0;
      omin_r <= '0;
      omax_r <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_contiguous   = cont_r;
  assign out_min_position = omin_r;
  assign out_max_position = omax_r;

endmodule

// ===== rtl/permutation_swap_range_contiguity_unit.sv =====
`timescale 1ns / 1ps

// Keeps a permutation of 1..N both ways (value at position, position of value)
// plus a min/max-position segment tree over value order, in memories with one
// read and one write port each. A load writes its leaf, then updates the
// L = clog2(2*MAX_ENTRIES) - 1 tree levels above it (10 at the default depth);
// a swap reads both values and both positions, writes them back and updates the
// tree above both leaves; a query walks the tree up level by level through the
// one read port of the tree memory. One word is worked on at a time; a finished
// result waits in an output register while the next word is taken. Loads must
// form a permutation of 1..N before queries mean anything. cfg writes N
// (saturated to MAX_ENTRIES) and must only be written while the block is idle.
module permutation_swap_range_contiguity_unit #(
  parameter int MAX_ENTRIES = pscu_pkg::DEF_MAX_ENTRIES
) (
  input logic clk,
  input logic rst_n,
  pscu_in_if.sink     in_ch,
  pscu_out_if.source  out_ch,
  pscu_cfg_if.sink    cfg_ch
);

  pscu_pkg::dp_cmd_t cmd;
  pscu_pkg::dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  pscu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pscu_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_valid         (in_ch.valid),
    .in_kind          (in_ch.kind),
    .in_first         (in_ch.first),
    .in_second        (in_ch.second),
    .cfg_valid        (cfg_ch.valid),
    .cfg_data         (cfg_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_contiguous   (out_ch.contiguous),
    .out_min_position (out_ch.min_position),
    .out_max_position (out_ch.max_position)
  );

endmodule

// ===== bench/permutation_swap_range_contiguity_unit_tb.sv =====
`timescale 1ns / 1ps

module permutation_swap_range_contiguity_unit_tb;

  localparam int ENTRIES = pscu_pkg::DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_LEN = 3000;

  typedef struct packed {
    pscu_pkg::kind_t kind;
    logic [10:0]     first;
    logic [10:0]     second;
  } word_t;

  typedef struct packed {
    logic        contiguous;
    logic [10:0] min_position;
    logic [10:0] max_position;
  } span_t;

  logic clk;
  logic rst_n;

  pscu_in_if  in_ch ();
  pscu_out_if out_ch ();
  pscu_cfg_if cfg_ch ();

  permutation_swap_range_contiguity_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the block's state
  int unsigned n_used;
  int unsigned val_at_pos [ENTRIES];
  int unsigned pos_of_val [ENTRIES];
  int unsigned min_node [2*ENTRIES];
  int unsigned max_node [2*ENTRIES];

  word_t pending_words [$];
  span_t expected_spans [$];
  int    mismatches;
  int    cycles;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_cycles;
  logic  hold_request;

  function automatic int unsigned active_n();
    return (n_used > ENTRIES) ? ENTRIES : n_used;
  endfunction

  function automatic void refresh_value(int unsigned v);
    int unsigned i;
    i = ENTRIES + v - 1;
    min_node[i] = pos_of_val[v-1];
    max_node[i] = pos_of_val[v-1];
    while (i > 1) begin
      i = i >> 1;
      min_node[i] = (min_node[2*i] < min_node[2*i+1]) ? min_node[2*i] : min_node[2*i+1];
      max_node[i] = (max_node[2*i] > max_node[2*i+1]) ? max_node[2*i] : max_node[2*i+1];
    end
  endfunction

  // Apply one word to the shadow state; queries push their expected span
  function automatic void predict_word(word_t w);
    int unsigned a, b, n, va, vb, t, l, r, mn, mx;
    span_t s;
    a = w.first;
    b = w.second;
    n = active_n();
    case (w.kind)
      pscu_pkg::KIND_LOAD: begin
        if (a >= 1 && a <= n && b >= 1 && b <= n) begin
          val_at_pos[a-1] = b;
          pos_of_val[b-1] = a;
          refresh_value(b);
        end
      end
      pscu_pkg::KIND_SWAP: begin
        if (a >= 1 && a <= n && b >= 1 && b <= n) begin
          va = val_at_pos[a-1];
          vb = val_at_pos[b-1];
          if (va >= 1 && va <= ENTRIES && vb >= 1 && vb <= ENTRIES) begin
            t = pos_of_val[va-1];
            pos_of_val[va-1] = pos_of_val[vb-1];
            pos_of_val[vb-1] = t;
            refresh_value(va);
            refresh_value(vb);
          end
          val_at_pos[a-1] = vb;
          val_at_pos[b-1] = va;
        end
      end
      pscu_pkg::KIND_QUERY: begin
        s = '0;
        if (!(a < 1 || b > n || a > b)) begin
          mn = 32'hFFFF_FFFF;
          mx = 0;
          l = ENTRIES + a - 1;
          r = ENTRIES + b;
          while (l < r) begin
            if (l[0]) begin
              if (min_node[l] < mn) mn = min_node[l];
              if (max_node[l] > mx) mx = max_node[l];
              l++;
            end
            if (r[0]) begin
              r--;
              if (min_node[r] < mn) mn = min_node[r];
              if (max_node[r] > mx) mx = max_node[r];
            end
            l = l >> 1;
            r = r >> 1;
          end
          s.contiguous   = (mx >= mn) && (mx - mn == b - a);
          s.min_position = mn[10:0];
          s.max_position = mx[10:0];
        end
        expected_spans.push_back(s);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_word({pscu_pkg::kind_t'(in_ch.kind), in_ch.first, in_ch.second});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          word_t w;
          w = pending_words.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.kind   <= w.kind;
          in_ch.first  <= w.first;
          in_ch.second <= w.second;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_request) begin
      hold_cycles <= HOLD_LEN;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_spans.size() == 0) begin
          report_mismatch("unexpected result", out_ch.min_position, 0);
        end else begin
          span_t e;
          e = expected_spans.pop_front();
          if (out_ch.contiguous !== e.contiguous)
            report_mismatch("contiguous", out_ch.contiguous, e.contiguous);
          if (out_ch.min_position !== e.min_position)
            report_mismatch("min_position", out_ch.min_position, e.min_position);
          if (out_ch.max_position !== e.max_position)
            report_mismatch("max_position", out_ch.max_position, e.max_position);
        end
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Config write while idle
  task automatic write_used(int unsigned v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v[10:0];
    do @(posedge clk); while (!cfg_ch.ready);
    n_used = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_spans.size() > 0)
      @(posedge clk);
    // swaps produce no result; give the block time to finish one
    repeat (120) @(posedge clk);
  endtask

  function automatic void add(pscu_pkg::kind_t k, int unsigned f, int unsigned s);
    pending_words.push_back({k, f[10:0], s[10:0]});
  endfunction

  // Load a random permutation of 1..n
  function automatic void add_permutation(int unsigned n);
    int unsigned perm [$];
    int unsigned j, t;
    for (int unsigned i = 1; i <= n; i++) perm.push_back(i);
    for (int unsigned i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    for (int unsigned i = 1; i <= n; i++) add(pscu_pkg::KIND_LOAD, i, perm[i-1]);
  endfunction

  // Random swaps, queries (some out of range), no-op words and out-of-range loads over a loaded permutation of size n
  function automatic void add_mix(int unsigned n, int count);
    int unsigned lo, hi;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add(pscu_pkg::KIND_SWAP, $urandom_range(n, 1), $urandom_range(n, 1));
        4: add(pscu_pkg::KIND_NONE, $urandom_range(2047), $urandom_range(2047));
        5: add(pscu_pkg::KIND_QUERY, $urandom_range(2047), $urandom_range(2047));
        6: add(pscu_pkg::KIND_LOAD, $urandom_range(2047, n + 1), $urandom_range(2047));
        default: begin
          lo = $urandom_range(n, 1);
          hi = $urandom_range(n, lo);
          add(pscu_pkg::KIND_QUERY, lo, hi);
        end
      endcase
    end
  endfunction

  initial begin
    int unsigned sizes [4];
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    hold_request = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_used = pscu_pkg::USED_RESET;
    in_ch.valid = 1'b0;
    in_ch.kind = pscu_pkg::KIND_LOAD;
    in_ch.first = '0;
    in_ch.second = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (val_at_pos[i]) begin
      val_at_pos[i] = 0;
      pos_of_val[i] = 0;
    end
    foreach (min_node[i]) begin
      min_node[i] = 0;
      max_node[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small N, edge cases
    write_used(4);
    add(pscu_pkg::KIND_LOAD, 0, 1);
    add(pscu_pkg::KIND_LOAD, 5, 1);
    add(pscu_pkg::KIND_LOAD, 1, 2047);
    add(pscu_pkg::KIND_NONE, 2047, 2047);
    add(pscu_pkg::KIND_LOAD, 1, 3); add(pscu_pkg::KIND_LOAD, 2, 1);
    add(pscu_pkg::KIND_LOAD, 3, 4); add(pscu_pkg::KIND_LOAD, 4, 2);
    add(pscu_pkg::KIND_QUERY, 1, 4);
    add(pscu_pkg::KIND_QUERY, 3, 4);
    add(pscu_pkg::KIND_QUERY, 1, 1);
    add(pscu_pkg::KIND_QUERY, 0, 2);
    add(pscu_pkg::KIND_QUERY, 3, 2);
    add(pscu_pkg::KIND_QUERY, 1, 5);
    add(pscu_pkg::KIND_QUERY, 2047, 2047);
    add(pscu_pkg::KIND_SWAP, 1, 4);
    add(pscu_pkg::KIND_SWAP, 2, 2);
    add(pscu_pkg::KIND_SWAP, 0, 1);
    add(pscu_pkg::KIND_SWAP, 1, 2047);
    add(pscu_pkg::KIND_QUERY, 1, 2);
    add(pscu_pkg::KIND_QUERY, 2, 3);
    drain();

    // Full size, then a long hold-off while queries keep coming
    write_used(1024);
    add_permutation(1024);
    drain();
    hold_request <= 1'b1;
    add(pscu_pkg::KIND_QUERY, 1, 1024);
    add(pscu_pkg::KIND_QUERY, 1024, 1024);
    add_mix(1024, 40);
    @(posedge clk);
    hold_request <= 1'b0;
    drain();

    // Random phases over several sizes and idling mixes
    sizes = '{1, 2, 37, 1500};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      write_used(sizes[p]);
      add_permutation((sizes[p] > ENTRIES) ? 16 : sizes[p]);
      add_mix((sizes[p] > ENTRIES) ? 16 : sizes[p], 50);
      drain();
    end

    write_used(20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_permutation(20);
    add_mix(20, 40);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
